/* rtl/bce_pkg.sv */
// Shared types, constants and the control store for the battery charge estimator.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package bce_pkg;

  // Field widths
  localparam int SAMPLE_W  = 12;
  localparam int SAMPLES   = 8;
  localparam int CNT_W     = $clog2(SAMPLES);
  localparam int SUM_W     = SAMPLE_W + CNT_W;
  localparam int MEAN_W    = SUM_W - CNT_W;
  localparam int RATIO_W   = 3;
  localparam int MV_W      = 14;
  localparam int PCT_W     = 7;
  localparam int ADC_MV_W  = 12;
  localparam int VOLT_W    = 15;
  localparam int ACC_W     = 24;
  localparam int DIV_SHIFT = 12;
  localparam int REM_W     = DIV_SHIFT + 1;

  // Conversion constants
  localparam int ADC_FULL_MV   = 3300;
  localparam int ADC_FULL_CODE = 4095;
  localparam int MV_FIELD_MAX  = 16383;

  localparam logic [RATIO_W-1:0] DIVIDER_RESET   = 3'd2;
  localparam logic [MV_W-1:0]    THRESHOLD_RESET = 14'd4150;

  // Discharge curve, highest voltage first
  localparam int CURVE_POINTS = 20;
  localparam int SEG_W        = $clog2(CURVE_POINTS - 1);
  localparam int DIFF_W       = 9;
  localparam int DP_W         = 4;
  localparam int NUM_W        = 10;
  localparam int RECIP_W      = 15;
  localparam int RECIP_SHIFT  = 20;
  localparam int PROD_W       = NUM_W + RECIP_W;

  localparam logic [VOLT_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    15'd4200, 15'd4150, 15'd4100, 15'd4050, 15'd4000,
    15'd3950, 15'd3900, 15'd3850, 15'd3800, 15'd3750,
    15'd3700, 15'd3650, 15'd3600, 15'd3550, 15'd3500,
    15'd3450, 15'd3400, 15'd3350, 15'd3300, 15'd3000
  };

  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80,
    7'd75,  7'd70, 7'd65, 7'd60, 7'd55,
    7'd50,  7'd45, 7'd40, 7'd35, 7'd28,
    7'd20,  7'd12, 7'd6,  7'd2,  7'd0
  };

  // ceil(2^20 / segment width): 50 mV segments, then the 300 mV tail
  localparam logic [RECIP_W-1:0] SEG_RECIP [CURVE_POINTS-1] = '{
    15'd20972, 15'd20972, 15'd20972, 15'd20972, 15'd20972,
    15'd20972, 15'd20972, 15'd20972, 15'd20972, 15'd20972,
    15'd20972, 15'd20972, 15'd20972, 15'd20972, 15'd20972,
    15'd20972, 15'd20972, 15'd20972, 15'd3496
  };

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIVIDER_RATIO   = 2'd0,
    CFG_CHARGE_THRESHOLD = 2'd1
  } cfg_idx_t;

  // Microcode
  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    OP_SCALE   = 3'd0,
    OP_DIVIDE  = 3'd1,
    OP_RATIO   = 3'd2,
    OP_SEGMENT = 3'd3,
    OP_PERCENT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_START    = 2'd1,
    COND_OUT_FREE = 2'd2
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  last;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    logic fire;
    logic last;
  } seq_ctl_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
  } blk_req_t;

  // Control store: step 0 waits for a full block, the last step waits for
  // the result register to be free.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      3'd0:    w = '{op: OP_SCALE,   cond: COND_START,    last: 1'b0};
      3'd1:    w = '{op: OP_DIVIDE,  cond: COND_ALWAYS,   last: 1'b0};
      3'd2:    w = '{op: OP_RATIO,   cond: COND_ALWAYS,   last: 1'b0};
      3'd3:    w = '{op: OP_SEGMENT, cond: COND_ALWAYS,   last: 1'b0};
      3'd4:    w = '{op: OP_PERCENT, cond: COND_OUT_FREE, last: 1'b1};
      default: w = '{op: OP_DIVIDE,  cond: COND_ALWAYS,   last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/bce_accum.sv */
// Sample accumulator: sums blocks of samples and hands each full block on.
// Depends on bce_pkg.
`default_nettype none

module bce_accum (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         sample_valid,
  output logic                              sample_stall,
  input  wire logic [bce_pkg::SAMPLE_W-1:0] adc_sample,
  input  wire logic                         busy,
  output bce_pkg::blk_req_t                 blk
);
  import bce_pkg::*;

  logic [SUM_W-1:0] sum, sum_next;
  logic [CNT_W-1:0] count, count_next;
  logic             last_sample;
  logic             take;
  logic [SUM_W-1:0] total;

  // The closing sample of a block waits until the sequencer is free
  assign last_sample  = (count == CNT_W'(SAMPLES - 1));
  assign sample_stall = last_sample && busy;
  assign take         = sample_valid && !sample_stall;
  assign total        = sum + SUM_W'(adc_sample);

  assign blk.start = take && last_sample;
  assign blk.sum   = total;

  always_comb begin
    sum_next   = sum;
    count_next = count;
    if (take) begin
      if (last_sample) begin
        sum_next   = '0;
        count_next = '0;
      end else begin
        sum_next   = total;
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else begin
      sum   <= sum_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/bce_useq.sv */
// Microcode sequencer: step counter, control store read and step conditions.
// Depends on bce_pkg.
`default_nettype none

module bce_useq (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire logic     out_free,
  output logic          busy,
  output bce_pkg::seq_ctl_t ctl
);
  import bce_pkg::*;

  logic [STEP_W-1:0] step, step_next;
  ucode_t            word;
  logic              fire;

  assign word = ucode_rom(step);

  // A step holds until its condition is met
  always_comb begin
    case (word.cond)
      COND_START:    fire = start;
      COND_OUT_FREE: fire = out_free;
      default:       fire = 1'b1;
    endcase
  end

  always_comb begin
    step_next = step;
    if (fire) begin
      step_next = word.last ? '0 : step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  assign busy     = (step != '0);
  assign ctl.op   = word.op;
  assign ctl.fire = fire;
  assign ctl.last = word.last;

endmodule

`default_nettype wire

/* rtl/bce_datapath.sv */
// Datapath: scaling, constant division, ratio, curve lookup and result register.
// Depends on bce_pkg; steered by bce_useq control words.
`default_nettype none

module bce_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bce_pkg::seq_ctl_t           ctl,
  input  wire logic [bce_pkg::SUM_W-1:0]   block_sum,
  input  wire logic [bce_pkg::RATIO_W-1:0] divider_ratio,
  input  wire logic [bce_pkg::MV_W-1:0]    charge_threshold_mv,
  output logic                             out_free,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic [bce_pkg::MV_W-1:0]         battery_mv,
  output logic [bce_pkg::PCT_W-1:0]        charge_percent,
  output logic                             charging
);
  import bce_pkg::*;

  logic [ACC_W-1:0]    acc;
  logic [ADC_MV_W-1:0] adc_mv;
  logic [VOLT_W-1:0]   volt;
  logic [NUM_W-1:0]    seg_num;
  logic [RECIP_W-1:0]  seg_recip;
  logic [PCT_W-1:0]    seg_lo;
  logic                sat_hi;
  logic                sat_lo;

  logic [MEAN_W-1:0]    mean;
  logic [DIV_SHIFT-1:0] q0;
  logic [REM_W-1:0]     rem;
  logic [ADC_MV_W-1:0]  quot;
  logic                 found;
  logic [SEG_W-1:0]     seg;
  logic [SEG_W-1:0]     seg_up;
  logic [DIFF_W-1:0]    diff;
  logic [DP_W-1:0]      dp;
  logic [NUM_W-1:0]     num;
  logic [PROD_W-1:0]    prod;
  logic [PCT_W-1:0]     pct;

  assign mean = block_sum[SUM_W-1:CNT_W];

  // x / 4095: floor(x / 4096) then one correction, remainder stays below 2*4095
  assign q0   = acc[ACC_W-1:DIV_SHIFT];
  assign rem  = {1'b0, acc[DIV_SHIFT-1:0]} + {1'b0, q0};
  assign quot = (rem >= REM_W'(ADC_FULL_CODE)) ? ADC_MV_W'(q0 + 1'b1) : ADC_MV_W'(q0);

  // Curve segment: first k with volt above the lower end of that segment
  always_comb begin
    found = 1'b0;
    seg   = '0;
    for (int k = 0; k < CURVE_POINTS - 1; k++) begin
      if (!found && (volt > CURVE_MV[k+1])) begin
        found = 1'b1;
        seg   = SEG_W'(k);
      end
    end
  end

  assign seg_up = seg + SEG_W'(1);
  assign diff   = DIFF_W'(volt - CURVE_MV[seg_up]);
  assign dp     = DP_W'(CURVE_PCT[seg] - CURVE_PCT[seg_up]);
  assign num    = NUM_W'(diff) * NUM_W'(dp);

  // Interpolation divide by reciprocal
  assign prod = PROD_W'(seg_num) * PROD_W'(seg_recip);
  always_comb begin
    if (sat_hi) begin
      pct = CURVE_PCT[0];
    end else if (sat_lo) begin
      pct = CURVE_PCT[CURVE_POINTS-1];
    end else begin
      pct = seg_lo + PCT_W'(prod[PROD_W-1:RECIP_SHIFT]);
    end
  end

  assign out_free = !result_valid || !result_stall;

  // Working registers, each loaded by its own microcode op
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      case (ctl.op)
        OP_SCALE:   acc    <= ACC_W'(mean) * ACC_W'(ADC_FULL_MV);
        OP_DIVIDE:  adc_mv <= quot;
        OP_RATIO:   volt   <= VOLT_W'(adc_mv) * VOLT_W'(divider_ratio);
        OP_SEGMENT: begin
          seg_num   <= num;
          seg_recip <= SEG_RECIP[seg];
          seg_lo    <= CURVE_PCT[seg_up];
          sat_hi    <= (volt >= CURVE_MV[0]);
          sat_lo    <= (volt <= CURVE_MV[CURVE_POINTS-1]);
        end
        OP_PERCENT: begin
          battery_mv     <= (volt > VOLT_W'(MV_FIELD_MAX)) ? MV_W'(MV_FIELD_MAX)
                                                           : volt[MV_W-1:0];
          charge_percent <= pct;
          charging       <= (volt > VOLT_W'(charge_threshold_mv));
        end
        default: begin
        end
      endcase
    end
  end

  // Result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.fire && (ctl.op == OP_PERCENT)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/battery_charge_estimator.sv */
// Battery charge estimator top level: configuration registers and module wiring.
// Depends on bce_pkg, bce_accum, bce_useq and bce_datapath.
//
// Usage:
//   Sample channel: adc_sample with sample_valid/sample_stall, one request per
//   cycle unless stalled. Each eighth request closes a block and yields a result.
//   Result channel: battery_mv, charge_percent, charging with
//   result_valid/result_stall. A result is held until it is taken.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Index 0 is the divider ratio, 1 the charge threshold in mV;
//   other indexes are ignored. Write only while no block is in flight.
//   Timing: the closing sample starts a five-step microprogram (scale, divide
//   by 4095, ratio, curve segment, percent); the percent step sets the result
//   valid. Samples of the next block keep flowing meanwhile; only a
//   block-closing sample stalls while the program runs. If the result is
//   stalled, the last step waits, so the program and any closing sample wait
//   with it. Throughput is one sample per cycle outside such stalls.
//   Reset: sum, count, sequencer and result valid clear; ratio 2, threshold
//   4150 mV.
`default_nettype none

module battery_charge_estimator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic [bce_pkg::SAMPLE_W-1:0]  adc_sample,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [bce_pkg::MV_W-1:0]           battery_mv,
  output logic [bce_pkg::PCT_W-1:0]          charge_percent,
  output logic                               charging,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bce_pkg::MV_W-1:0]      cfg_data
);
  import bce_pkg::*;

  logic [RATIO_W-1:0] divider_ratio;
  logic [MV_W-1:0]    charge_threshold_mv;
  blk_req_t           blk;
  seq_ctl_t           ctl;
  logic               busy;
  logic               out_free;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_ratio       <= DIVIDER_RESET;
      charge_threshold_mv <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DIVIDER_RATIO) begin
        divider_ratio <= cfg_data[RATIO_W-1:0];
      end
      if (cfg_index == CFG_CHARGE_THRESHOLD) begin
        charge_threshold_mv <= cfg_data;
      end
    end
  end

  bce_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .adc_sample   (adc_sample),
    .busy         (busy),
    .blk          (blk)
  );

  bce_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .start    (blk.start),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  bce_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .block_sum           (blk.sum),
    .divider_ratio       (divider_ratio),
    .charge_threshold_mv (charge_threshold_mv),
    .out_free            (out_free),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .battery_mv          (battery_mv),
    .charge_percent      (charge_percent),
    .charging            (charging)
  );

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for battery_charge_estimator: random and directed sample
// streams, varied register settings, and a cycle-free predictor of every block result.
// Depends on rtl/bce_pkg.sv and rtl/battery_charge_estimator.sv.

module testbench;
  import bce_pkg::*;

  // Behaviour constants of the gauge
  localparam int AVG_BLOCK = 8;
  localparam int FULL_MV   = 3300;
  localparam int FULL_CODE = 4095;
  localparam int MV_CEIL   = 16383;
  localparam int MAX_CODE  = 4095;

  // Discharge curve, highest voltage first
  localparam int KNEES = 20;
  localparam int KNEE_MV [KNEES] = '{
    4200, 4150, 4100, 4050, 4000, 3950, 3900, 3850, 3800, 3750,
    3700, 3650, 3600, 3550, 3500, 3450, 3400, 3350, 3300, 3000
  };
  localparam int KNEE_PCT [KNEES] = '{
    100, 95, 90, 85, 80, 75, 70, 65, 60, 55,
    50, 45, 40, 35, 28, 20, 12, 6, 2, 0
  };

  // Index codes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Result-side back-pressure modes
  localparam int STALL_NONE   = 0;
  localparam int STALL_COIN   = 1;
  localparam int STALL_RUNS   = 2;
  localparam int STALL_SPARSE = 3;

  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 8;
  localparam int BLOCKS        = 30;

  typedef struct packed {
    logic                hold;   // pause until all readings are back
    logic [SAMPLE_W-1:0] code;
  } sample_req_t;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic             chg;
  } reading_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  logic [SAMPLE_W-1:0]  adc_sample   = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [MV_W-1:0]      battery_mv;
  logic [PCT_W-1:0]     charge_percent;
  logic                 charging;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [MV_W-1:0]      cfg_data     = '0;

  // Predictor state: register copies and the open block
  logic [RATIO_W-1:0] ratio_reg  = DIVIDER_RESET;
  logic [MV_W-1:0]    thresh_reg = THRESHOLD_RESET;
  int                 block_sum  = 0;
  int                 block_fill = 0;

  sample_req_t samples_pending[$];
  reading_t    readings_due[$];
  logic        sample_taken = 1'b0;
  int          cfg_writes   = 0;
  int          fail_count   = 0;

  battery_charge_estimator DUT (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .adc_sample     (adc_sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .battery_mv     (battery_mv),
    .charge_percent (charge_percent),
    .charging       (charging),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // State of charge by truncating interpolation along the curve
  function automatic int soc_percent(input int volt);
    int k;
    if (volt >= KNEE_MV[0]) return 100;
    if (volt <= KNEE_MV[KNEES-1]) return 0;
    for (k = 0; k < KNEES - 1; k++) begin
      if (volt <= KNEE_MV[k] && volt > KNEE_MV[k+1])
        return KNEE_PCT[k+1] + ((volt - KNEE_MV[k+1]) * (KNEE_PCT[k] - KNEE_PCT[k+1]))
               / (KNEE_MV[k] - KNEE_MV[k+1]);
    end
    return 0;
  endfunction

  // Reading for one closed block; percent and flag use the unsaturated voltage
  function automatic reading_t gauge_reading(input int sum, input int ratio, input int thresh);
    reading_t r;
    int       adc_mv;
    int       volt;
    adc_mv = ((sum / AVG_BLOCK) * FULL_MV) / FULL_CODE;
    volt   = adc_mv * ratio;
    r.mv   = (volt > MV_CEIL) ? MV_W'(MV_CEIL) : MV_W'(volt);
    r.pct  = PCT_W'(soc_percent(volt));
    r.chg  = volt > thresh;
    return r;
  endfunction

  // Sample side: predict on every accepted request
  always @(posedge clk) begin
    sample_taken <= !rst && sample_valid && !sample_stall;
    if (!rst && sample_valid && !sample_stall) begin
      block_sum  += adc_sample;
      block_fill += 1;
      if (block_fill == AVG_BLOCK) begin
        readings_due.push_back(gauge_reading(block_sum, ratio_reg, thresh_reg));
        block_sum  = 0;
        block_fill = 0;
      end
    end
  end

  // Register writes update the predictor copy; spare indexes change nothing
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIVIDER_RATIO:    ratio_reg  <= cfg_data[RATIO_W-1:0];
        CFG_CHARGE_THRESHOLD: thresh_reg <= cfg_data;
        default: ;
      endcase
      cfg_writes <= cfg_writes + 1;
    end
  end

  // Result side: compare each accepted result with the oldest reading due
  always @(posedge clk) begin : check_result
    reading_t want;
    if (!rst && result_valid && !result_stall) begin
      if (readings_due.size() == 0) begin
        $error("unexpected result: battery_mv %0d charge_percent %0d charging %0b",
               battery_mv, charge_percent, charging);
        fail_count++;
      end else begin
        want = readings_due.pop_front();
        if (battery_mv !== want.mv) begin
          $error("battery_mv expected %0d got %0d", want.mv, battery_mv);
          fail_count++;
        end
        if (charge_percent !== want.pct) begin
          $error("charge_percent expected %0d got %0d", want.pct, charge_percent);
          fail_count++;
        end
        if (charging !== want.chg) begin
          $error("charging expected %0b got %0b", want.chg, charging);
          fail_count++;
        end
      end
    end
  end

  // Request driver: bursts with random gaps, hold markers wait for a drained pipe
  int burst_left = 0;
  int gap_left   = 0;
  always @(negedge clk) begin : feed
    sample_req_t nxt;
    if (!rst && (!sample_valid || sample_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (samples_pending.size() != 0 && samples_pending[0].hold) begin
        sample_valid <= 1'b0;
        if (readings_due.size() == 0) void'(samples_pending.pop_front());
      end else if (samples_pending.size() != 0) begin
        nxt          = samples_pending.pop_front();
        sample_valid <= 1'b1;
        adc_sample   <= nxt.code;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Result stall: mode rotates through the four back-pressure modes
  int cyc = 0;
  always @(negedge clk) begin
    cyc++;
    case ((cyc / 128) % 4)
      STALL_NONE:   result_stall <= 1'b0;
      STALL_COIN:   result_stall <= 1'($urandom_range(0, 1));
      STALL_RUNS:   result_stall <= (cyc % 23) < 15;
      STALL_SPARSE: result_stall <= ($urandom_range(0, 4) == 0);
      default:      result_stall <= 1'b0;
    endcase
  end

  task automatic push_code(input logic hold, input int code);
    sample_req_t r;
    r.hold = hold;
    r.code = SAMPLE_W'(code);
    samples_pending.push_back(r);
  endtask

  // Eight samples alternating between two codes
  task automatic push_block(input int code_a, input int code_b);
    for (int i = 0; i < AVG_BLOCK; i++) push_code(1'b0, (i % 2 == 0) ? code_a : code_b);
  endtask

  // Random blocks: mostly aimed at the curve for the current ratio, some noise
  task automatic queue_blocks(input int n_blocks);
    int kind;
    int volt;
    int adc;
    int mean;
    int jit;
    int s;
    for (int b = 0; b < n_blocks; b++) begin
      if (b % 9 == 4) push_code(1'b1, 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        for (int i = 0; i < AVG_BLOCK; i++) push_code(1'b0, $urandom_range(0, MAX_CODE));
      end else if (kind == 1) begin
        s = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? MAX_CODE : 0)
                                        : $urandom_range(0, MAX_CODE);
        push_block(s, s);
      end else begin
        if (ratio_reg == 0) begin
          mean = $urandom_range(0, MAX_CODE);
        end else begin
          volt = $urandom_range(2900, 4300);
          adc  = volt / ratio_reg;
          if (adc > FULL_MV) adc = FULL_MV;
          mean = (adc * FULL_CODE + FULL_MV - 1) / FULL_MV;
          if (mean > MAX_CODE) mean = MAX_CODE;
        end
        jit = $urandom_range(0, 8);
        for (int i = 0; i < AVG_BLOCK; i++) begin
          s = mean + $urandom_range(0, 2 * jit) - jit;
          if (s < 0) s = 0;
          if (s > MAX_CODE) s = MAX_CODE;
          push_code(1'b0, s);
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] data);
    int target;
    target = cfg_writes + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    wait (cfg_writes == target);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // All requests sent, all readings back, then let the pipe empty
  task automatic wait_drained();
    while (samples_pending.size() != 0 || sample_valid || readings_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : run
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: full scale, then alternating extremes, then random
    push_block(MAX_CODE, MAX_CODE);
    push_block(0, MAX_CODE);
    queue_blocks(BLOCKS - 2);
    wait_drained();

    for (int p = 1; p < PHASES; p++) begin
      case (p)
        1: begin
          // high data bits set: ratio field keeps only its low bits
          write_reg(CFG_DIVIDER_RATIO, 14'h3FF9);
          write_reg(CFG_CHARGE_THRESHOLD, 14'd3300);
        end
        2: begin
          write_reg(CFG_DIVIDER_RATIO, 14'd4);
          write_reg(CFG_CHARGE_THRESHOLD, 14'd0);
        end
        3: begin
          write_reg(CFG_DIVIDER_RATIO, 14'd0);
          write_reg(CFG_CHARGE_THRESHOLD, 14'h3FFF);
        end
        4: begin
          write_reg(CFG_DIVIDER_RATIO, 14'd7);
          write_reg(CFG_CHARGE_THRESHOLD, MV_W'($urandom_range(0, MV_CEIL)));
        end
        5: begin
          write_reg(CFG_DIVIDER_RATIO, 14'd3);
          write_reg(CFG_CHARGE_THRESHOLD, MV_W'($urandom_range(3000, 4300)));
        end
        6: begin
          write_reg(CFG_DIVIDER_RATIO, 14'd5);
          write_reg(CFG_CHARGE_THRESHOLD, 14'd8000);
          write_reg(CFG_SPARE_A, MV_W'($urandom_range(0, MV_CEIL)));
          write_reg(CFG_SPARE_B, 14'h3FFF);
        end
        default: begin
          write_reg(CFG_DIVIDER_RATIO, 14'd6);
          write_reg(CFG_CHARGE_THRESHOLD, MV_W'($urandom_range(0, MV_CEIL)));
        end
      endcase
      @(posedge clk);
      // full scale at ratio 1 lands exactly on the threshold: not charging
      if (p == 1) push_block(MAX_CODE, MAX_CODE);
      queue_blocks((p == 1) ? BLOCKS - 1 : BLOCKS);
      wait_drained();
    end

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
